/* rtl/sbhe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPI bootloader host engine package
// Shared types, frame constants and helper functions for the host engine.
// ----------------------------------------------------------------------------
package sbhe_pkg;

    localparam logic [7:0]  BYTE_ACK         = 8'h79;
    localparam logic [7:0]  BYTE_NACK        = 8'h1F;
    localparam logic [7:0]  BYTE_SOF         = 8'h5A;
    localparam logic [7:0]  BYTE_RSOF        = 8'hA5;
    localparam logic [7:0]  CMD_READ         = 8'h11;
    localparam logic [7:0]  CMD_WRITE        = 8'h31;
    localparam logic [7:0]  CMD_ERASE        = 8'h44;
    localparam logic [7:0]  BYTE_ERASE_ALL   = 8'hFF;
    localparam logic [7:0]  BYTE_FILL        = 8'h00;
    localparam logic [15:0] POLL_LIMIT_RESET = 16'd1000;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_WDATA = 2'd1;
    localparam logic [1:0] REQ_RX    = 2'd2;

    localparam logic [1:0] OP_SYNC  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_ERASE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SYNC    = 2'd1;
    localparam logic [1:0] ST_NACK    = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    localparam logic [8:0] STAGE_ADDR = 9'd0;
    localparam logic [8:0] STAGE_LEN  = 9'd1;
    localparam logic [8:0] STAGE_DATA = 9'd2;

    typedef enum logic [4:0] {
        PH_IDLE, PH_SYNC_SOF, PH_SYNC_RD, PH_CMD_SOF, PH_CMD_OP, PH_CMD_INV,
        PH_ACK_DUMMY, PH_ACK_POLL, PH_ACK_ECHO, PH_ADDR, PH_LEN, PH_LEN_INV,
        PH_WR_WAIT, PH_WR_DATA, PH_WR_SUM, PH_RD_DUMMY, PH_RD_DATA,
        PH_ER_0, PH_ER_1, PH_ER_2
    } t_phase;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  operation;
        logic [31:0] target_address;
        logic [7:0]  length_minus_one;
        logic [7:0]  byte_value;
    } t_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       need_write_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       op_done;
        logic [1:0] op_status;
    } t_result;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  cur_op;
        logic [31:0] addr;
        logic [7:0]  len;
        logic [8:0]  byte_count;
        logic [15:0] poll_count;
        logic [7:0]  run_xor;
    } t_state;

    function automatic t_result f_send(input logic [7:0] b);
        t_result r;
        r = '0;
        r.tx_valid = 1'b1;
        r.tx_byte  = b;
        return r;
    endfunction

    function automatic t_result f_finish(input logic [1:0] st);
        t_result r;
        r = '0;
        r.op_done   = 1'b1;
        r.op_status = st;
        return r;
    endfunction

    function automatic logic [7:0] f_cmd_code(input logic [1:0] op);
        logic [7:0] c;
        unique case (op)
            OP_READ:  c = CMD_READ;
            OP_WRITE: c = CMD_WRITE;
            default:  c = CMD_ERASE;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] f_addr_byte(input logic [31:0] a, input logic [1:0] idx);
        logic [7:0] v;
        unique case (idx)
            2'd0:    v = a[31:24];
            2'd1:    v = a[23:16];
            2'd2:    v = a[15:8];
            default: v = a[7:0];
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* rtl/spi_bootloader_host_engine_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPI bootloader host engine core
// Frames sync, read, write and mass erase exchanges one SPI byte at a time.
// ----------------------------------------------------------------------------
//  Channel   Signals                     Direction
//  input     i_in_valid / o_in_ready     request and received-byte beats in
//  output    o_out_valid / i_out_ready   next-byte and status beats out
//  config    i_cfg_we / i_cfg_wdata      acknowledge poll limit write
//
// A beat is registered on acceptance and processed when the output can take
// its result, so beats may arrive back to back unless the output stalls.
// Its result lands in the output register, which is refilled in the same
// cycle it is taken. A stalled output holds the input register, which in
// turn drops o_in_ready. Reset leaves the engine idle with a poll limit of 1000.
// ----------------------------------------------------------------------------
module spi_bootloader_host_engine_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_target_address,
    input  wire logic [7:0]  i_length_minus_one,
    input  wire logic [7:0]  i_byte_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_tx_valid,
    output logic [7:0]       o_tx_byte,
    output logic             o_need_write_byte,
    output logic             o_read_valid,
    output logic [7:0]       o_read_byte,
    output logic             o_op_done,
    output logic [1:0]       o_op_status,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);
    import sbhe_pkg::*;

    logic        r_in_vld;
    t_item       r_in;
    logic        r_out_vld;
    t_result     r_out;
    t_state      r_state;
    logic [15:0] r_poll_limit;

    t_state      n_state;
    t_result     n_result;
    logic        n_has_result;
    logic        advance;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    sbhe_step u_step (
        .i_state      (r_state),
        .i_item       (r_in),
        .i_poll_limit (r_poll_limit),
        .o_state      (n_state),
        .o_has_result (n_has_result),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= POLL_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_poll_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.req_type         <= i_req_type;
            r_in.operation        <= i_operation;
            r_in.target_address   <= i_target_address;
            r_in.length_minus_one <= i_length_minus_one;
            r_in.byte_value       <= i_byte_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, default: '0};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && n_has_result) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_has_result) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_tx_valid        = r_out.tx_valid;
    assign o_tx_byte         = r_out.tx_byte;
    assign o_need_write_byte = r_out.need_write_byte;
    assign o_read_valid      = r_out.read_valid;
    assign o_read_byte       = r_out.read_byte;
    assign o_op_done         = r_out.op_done;
    assign o_op_status       = r_out.op_status;

endmodule
`default_nettype wire

/* rtl/sbhe_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPI bootloader host engine step logic
// Computes the next engine state and the result beat for one input beat.
// ----------------------------------------------------------------------------
module sbhe_step (
    input  var sbhe_pkg::t_state  i_state,
    input  var sbhe_pkg::t_item   i_item,
    input  wire logic [15:0]      i_poll_limit,
    output var sbhe_pkg::t_state  o_state,
    output logic                  o_has_result,
    output var sbhe_pkg::t_result o_result
);
    import sbhe_pkg::*;

    logic [15:0] poll_next;
    logic [8:0]  cnt_next;
    logic [8:0]  len_ext;
    logic [7:0]  addr_v;
    logic [7:0]  cmd;

    assign poll_next = i_state.poll_count + 16'd1;
    assign cnt_next  = i_state.byte_count + 9'd1;
    assign len_ext   = {1'b0, i_state.len};
    assign addr_v    = f_addr_byte(i_state.addr, i_state.byte_count[1:0]);
    assign cmd       = f_cmd_code(i_state.cur_op);

    always_comb begin
        o_state      = i_state;
        o_has_result = 1'b0;
        o_result     = '0;
        unique case (i_item.req_type)
            REQ_START: begin
                o_state.cur_op     = i_item.operation;
                o_state.addr       = i_item.target_address;
                o_state.len        = i_item.length_minus_one;
                o_state.byte_count = '0;
                o_state.poll_count = '0;
                o_state.run_xor    = '0;
                o_state.phase      = (i_item.operation == OP_SYNC) ? PH_SYNC_SOF : PH_CMD_SOF;
                o_has_result       = 1'b1;
                o_result           = f_send(BYTE_SOF);
            end
            REQ_WDATA: begin
                if (i_state.phase == PH_WR_WAIT) begin
                    o_state.run_xor    = i_state.run_xor ^ i_item.byte_value;
                    o_state.byte_count = cnt_next;
                    o_state.phase      = PH_WR_DATA;
                    o_has_result       = 1'b1;
                    o_result           = f_send(i_item.byte_value);
                end
            end
            REQ_RX: begin
                o_has_result = 1'b1;
                unique case (i_state.phase)
                    PH_SYNC_SOF: begin
                        o_state.phase = PH_SYNC_RD;
                        o_result      = f_send(BYTE_FILL);
                    end
                    PH_SYNC_RD: begin
                        if (i_item.byte_value != BYTE_RSOF) begin
                            o_state.phase = PH_IDLE;
                            o_result      = f_finish(ST_SYNC);
                        end else begin
                            o_state.byte_count = STAGE_ADDR;
                            o_state.phase      = PH_ACK_DUMMY;
                            o_result           = f_send(BYTE_FILL);
                        end
                    end
                    PH_CMD_SOF: begin
                        o_state.phase = PH_CMD_OP;
                        o_result      = f_send(cmd);
                    end
                    PH_CMD_OP: begin
                        o_state.phase = PH_CMD_INV;
                        o_result      = f_send(~cmd);
                    end
                    PH_CMD_INV: begin
                        o_state.byte_count = STAGE_ADDR;
                        o_state.phase      = PH_ACK_DUMMY;
                        o_result           = f_send(BYTE_FILL);
                    end
                    PH_ACK_DUMMY: begin
                        o_state.poll_count = '0;
                        o_state.phase      = PH_ACK_POLL;
                        o_result           = f_send(BYTE_FILL);
                    end
                    PH_ACK_POLL: begin
                        if (i_item.byte_value == BYTE_ACK) begin
                            o_state.phase = PH_ACK_ECHO;
                            o_result      = f_send(BYTE_ACK);
                        end else if (i_item.byte_value == BYTE_NACK) begin
                            o_state.phase = PH_IDLE;
                            o_result      = f_finish(ST_NACK);
                        end else begin
                            o_state.poll_count = poll_next;
                            if (poll_next >= i_poll_limit) begin
                                o_state.phase = PH_IDLE;
                                o_result      = f_finish(ST_TIMEOUT);
                            end else begin
                                o_result = f_send(BYTE_FILL);
                            end
                        end
                    end
                    PH_ACK_ECHO: begin
                        if (i_state.cur_op == OP_SYNC) begin
                            o_state.phase = PH_IDLE;
                            o_result      = f_finish(ST_OK);
                        end else if (i_state.byte_count == STAGE_ADDR) begin
                            if (i_state.cur_op == OP_ERASE) begin
                                o_state.phase = PH_ER_0;
                                o_result      = f_send(BYTE_ERASE_ALL);
                            end else begin
                                o_state.run_xor    = i_state.addr[31:24];
                                o_state.byte_count = 9'd1;
                                o_state.phase      = PH_ADDR;
                                o_result           = f_send(i_state.addr[31:24]);
                            end
                        end else if (i_state.byte_count == STAGE_LEN) begin
                            o_state.run_xor = i_state.len;
                            o_state.phase   = PH_LEN;
                            o_result        = f_send(i_state.len);
                        end else if (i_state.cur_op == OP_READ) begin
                            o_state.phase = PH_RD_DUMMY;
                            o_result      = f_send(BYTE_FILL);
                        end else begin
                            o_state.phase = PH_IDLE;
                            o_result      = f_finish(ST_OK);
                        end
                    end
                    PH_ADDR: begin
                        if (i_state.byte_count < 9'd4) begin
                            o_state.run_xor    = i_state.run_xor ^ addr_v;
                            o_state.byte_count = cnt_next;
                            o_result           = f_send(addr_v);
                        end else if (i_state.byte_count == 9'd4) begin
                            o_state.byte_count = 9'd5;
                            o_result           = f_send(i_state.run_xor);
                        end else begin
                            o_state.byte_count = STAGE_LEN;
                            o_state.phase      = PH_ACK_DUMMY;
                            o_result           = f_send(BYTE_FILL);
                        end
                    end
                    PH_LEN: begin
                        if (i_state.cur_op == OP_READ) begin
                            o_state.phase = PH_LEN_INV;
                            o_result      = f_send(~i_state.len);
                        end else begin
                            o_state.byte_count       = '0;
                            o_state.phase            = PH_WR_WAIT;
                            o_result.need_write_byte = 1'b1;
                        end
                    end
                    PH_LEN_INV, PH_WR_SUM, PH_ER_2: begin
                        o_state.byte_count = STAGE_DATA;
                        o_state.phase      = PH_ACK_DUMMY;
                        o_result           = f_send(BYTE_FILL);
                    end
                    PH_WR_DATA: begin
                        if (i_state.byte_count > len_ext) begin
                            o_state.phase = PH_WR_SUM;
                            o_result      = f_send(i_state.run_xor);
                        end else begin
                            o_state.phase            = PH_WR_WAIT;
                            o_result.need_write_byte = 1'b1;
                        end
                    end
                    PH_RD_DUMMY: begin
                        o_state.byte_count = '0;
                        o_state.phase      = PH_RD_DATA;
                        o_result           = f_send(BYTE_FILL);
                    end
                    PH_RD_DATA: begin
                        o_state.byte_count  = cnt_next;
                        o_result.read_valid = 1'b1;
                        o_result.read_byte  = i_item.byte_value;
                        if (cnt_next > len_ext) begin
                            o_state.phase    = PH_IDLE;
                            o_result.op_done = 1'b1;
                        end else begin
                            o_result.tx_valid = 1'b1;
                        end
                    end
                    PH_ER_0: begin
                        o_state.phase = PH_ER_1;
                        o_result      = f_send(BYTE_ERASE_ALL);
                    end
                    PH_ER_1: begin
                        o_state.phase = PH_ER_2;
                        o_result      = f_send(BYTE_FILL);
                    end
                    default: begin
                        o_has_result = 1'b0;
                    end
                endcase
            end
            default: begin
                o_has_result = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire
